@@ rtl/negative_run_sum_histogram_macros.svh @@
// Assertion macros for the negative run sum histogram block.
// Used by the top level only; expects a clock named clock and a reset named reset.
`ifndef NEGATIVE_RUN_SUM_HISTOGRAM_MACROS_SVH
`define NEGATIVE_RUN_SUM_HISTOGRAM_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define NRSH_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check a condition later than its trigger.
`define NRSH_ASSERT_LATER(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##2 (cons)) \
      else $error(msg);

`endif

@@ rtl/nrsh_pkg.sv @@
// Shared types and constants for the negative run sum histogram block.
// No dependencies; every RTL module imports it.
package nrsh_pkg;

   localparam int HIST_DEPTH = 512;
   localparam int FRAC_BITS  = 8;
   localparam int ADDR_W     = $clog2(HIST_DEPTH);

   localparam int SAMPLE_W   = 16;
   localparam int MAG_W      = SAMPLE_W + 1;
   localparam int ACC_W      = 32;
   localparam int ACC_SUM_W  = ACC_W + 1;
   localparam int COUNT_W    = 32;
   localparam int POS_W      = 16;
   localparam int MASK_W     = 8;
   localparam int BIN_IDX_W  = 9;

   localparam logic [MASK_W-1:0] MASK_RESET = 8'd33;
   localparam int ROUND_HALF = (FRAC_BITS == 0) ? 0 : (1 << (FRAC_BITS - 1));

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   typedef enum logic {
      CMD_SAMPLE = 1'b0,
      CMD_READ   = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type                     command;
      logic signed [SAMPLE_W-1:0]  sample_value;
      logic                        last_in_sequence;
      logic                        is_significant;
      logic [BIN_IDX_W-1:0]        bin_index;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] significant_count;
      logic [COUNT_W-1:0] other_count;
   } rsp_type;

   // Work handed from the sample front end to the histogram stage.
   typedef struct packed {
      logic                 bump;   // a run closed: count it (if its bin is nonzero)
      logic                 rd;     // read both counts of one bin
      logic                 sel;    // significant histogram when set
      logic [ACC_W-1:0]     acc;    // closed run sum, FRAC_BITS fraction bits
      logic [BIN_IDX_W-1:0] idx;    // bin to read
   } op_type;

   // Status of the histogram stage seen by the top level.
   typedef struct packed {
      logic busy;        // clearing pass after reset in progress
      logic rd_pending;  // a read sits between memory read and response push
   } hist_stat_type;

endpackage

@@ rtl/negative_run_sum_histogram.sv @@
// Negative run sum histogram: top level; uses nrsh_pkg, nrsh_front, nrsh_hist, nrsh_rsp_fifo.
// Throughput: one beat per cycle while req_ready is high, samples and reads mixed freely;
//   the histogram memories do one read-modify-write per cycle, with forwarding between
//   back-to-back updates. A read beat passes the front-end and histogram stage registers
//   into the output queue. Reset: synchronous; then a clearing pass over all HIST_DEPTH (512)
//   entries zeroes both histograms, with req_ready low; csr writes are taken during the pass.
`include "negative_run_sum_histogram_macros.svh"

module negative_run_sum_histogram (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  nrsh_pkg::req_type           req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output nrsh_pkg::rsp_type           rsp_data,
   input  logic                        csr_wr_en,
   input  logic [nrsh_pkg::MASK_W-1:0] csr_wr_data
);
   import nrsh_pkg::*;

   localparam int OCC_W = FIFO_CNT_W + 1;

   op_type                 op;
   hist_stat_type          stat;
   logic                   rsp_push;
   rsp_type                push_data;
   logic [FIFO_CNT_W-1:0]  fifo_count;
   logic [OCC_W-1:0]       occupancy;
   logic                   accept;

   // Credit check: every read in flight already owns a queue slot, so the
   // pipeline itself never stalls and only the input waits on a full queue.
   assign occupancy = OCC_W'(fifo_count) + OCC_W'(op.rd) + OCC_W'(stat.rd_pending);
   assign req_ready = !stat.busy && (occupancy < OCC_W'(FIFO_DEPTH));
   assign accept    = req_valid && req_ready;

   // Stage 1: mask, position and run accumulator; closes runs.
   nrsh_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .accept      (accept),
      .req_data    (req_data),
      .op          (op)
   );

   // Stages 2 and 3: bin rounding, memory read, saturating increment and write back.
   nrsh_hist u_hist (
      .clock    (clock),
      .reset    (reset),
      .op       (op),
      .stat     (stat),
      .rsp_push (rsp_push),
      .rsp_data (push_data)
   );

   // Output queue: hold results while the consumer stalls.
   nrsh_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (push_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data),
      .count     (fifo_count)
   );

   // Reads in flight plus queued results never exceed the queue depth.
   `NRSH_ASSERT_NOW(a_credit_bound, 1'b1, occupancy <= OCC_W'(FIFO_DEPTH), "queue overbooked")
   // Every read beat reaches the queue through the front-end and histogram stage registers.
   `NRSH_ASSERT_LATER(a_read_rsp, accept && req_data.command == CMD_READ, rsp_push, "read lost")
   // A sample beat never produces a response.
   `NRSH_ASSERT_LATER(a_sample_quiet, accept && req_data.command == CMD_SAMPLE, !rsp_push, "bad rsp")

endmodule

@@ rtl/nrsh_rsp_fifo.sv @@
// Small response queue that decouples the histogram pipeline from the result channel.
// Depends on nrsh_pkg; space is reserved by the top level before a read enters.
module nrsh_rsp_fifo (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  nrsh_pkg::rsp_type             push_data,
   output logic                          out_valid,
   input  logic                          out_ready,
   output nrsh_pkg::rsp_type             out_data,
   output logic [nrsh_pkg::FIFO_CNT_W-1:0] count
);
   import nrsh_pkg::*;

   rsp_type                 entry_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]   count_ff, count_in;
   logic                    pop;

   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign count     = count_ff;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      priority if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end else begin
         // both or neither: hold the count
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/nrsh_front.sv @@
// Sample front end: mask register, sequence position and run accumulator.
// Depends on nrsh_pkg; emits one op_type per beat toward the histogram stage.
module nrsh_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [nrsh_pkg::MASK_W-1:0] csr_wr_data,
   input  logic                        accept,
   input  nrsh_pkg::req_type           req_data,
   output nrsh_pkg::op_type            op
);
   import nrsh_pkg::*;

   localparam logic [MAG_W-1:0] MAG_SPAN = MAG_W'(1 << SAMPLE_W);

   logic [MASK_W-1:0]     mask_ff, mask_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [ACC_W-1:0]      acc_ff, acc_in;
   op_type                op_ff, op_in;

   logic [SAMPLE_W-1:0]   raw;
   logic [MAG_W-1:0]      mag;
   logic [ACC_SUM_W-1:0]  sum;
   logic [ACC_W-1:0]      acc_add;
   logic                  unmasked;
   logic                  negative;

   assign raw      = req_data.sample_value;
   assign negative = raw[SAMPLE_W-1];
   assign mag      = MAG_SPAN - {1'b0, raw};
   assign sum      = {1'b0, acc_ff} + ACC_SUM_W'(mag);
   assign acc_add  = sum[ACC_W] ? '1 : sum[ACC_W-1:0];
   assign unmasked = (pos_ff >= POS_W'(mask_ff));
   assign mask_in  = csr_wr_en ? csr_wr_data : mask_ff;
   assign op       = op_ff;

   always_comb begin
      pos_in    = pos_ff;
      acc_in    = acc_ff;
      op_in     = '0;
      op_in.sel = req_data.is_significant;
      op_in.idx = req_data.bin_index;
      op_in.acc = acc_ff;
      if (accept) begin
         unique case (req_data.command)
            CMD_READ: begin
               op_in.rd = 1'b1;
            end
            CMD_SAMPLE: begin
               if (unmasked) begin
                  if (negative) begin
                     acc_in     = acc_add;
                     op_in.acc  = acc_add;
                     op_in.bump = req_data.last_in_sequence;
                  end else begin
                     // non-negative sample closes the open run
                     acc_in     = '0;
                     op_in.bump = 1'b1;
                  end
               end
               if (pos_ff != '1) begin
                  pos_in = pos_ff + 1'b1;
               end
               if (req_data.last_in_sequence) begin
                  acc_in = '0;
                  pos_in = '0;
               end
            end
            default: begin
               op_in.rd = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      op_ff.sel <= op_in.sel;
      op_ff.acc <= op_in.acc;
      op_ff.idx <= op_in.idx;
      if (reset) begin
         mask_ff    <= MASK_RESET;
         pos_ff     <= '0;
         acc_ff     <= '0;
         op_ff.bump <= 1'b0;
         op_ff.rd   <= 1'b0;
      end else begin
         mask_ff    <= mask_in;
         pos_ff     <= pos_in;
         acc_ff     <= acc_in;
         op_ff.bump <= op_in.bump;
         op_ff.rd   <= op_in.rd;
      end
   end

endmodule

@@ rtl/nrsh_hist.sv @@
// Histogram stage: two count memories with read-modify-write, forwarding and a clear sweep.
// Depends on nrsh_pkg; consumes op_type from the front end, pushes read results.
module nrsh_hist (
   input  logic                    clock,
   input  logic                    reset,
   input  nrsh_pkg::op_type        op,
   output nrsh_pkg::hist_stat_type stat,
   output logic                    rsp_push,
   output nrsh_pkg::rsp_type       rsp_data
);
   import nrsh_pkg::*;

   typedef struct packed {
      logic              bump;
      logic              rd;
      logic              sel;
      logic              oor;
      logic [ADDR_W-1:0] addr;
   } stage_type;

   logic [COUNT_W-1:0]    sig_mem [HIST_DEPTH];
   logic [COUNT_W-1:0]    oth_mem [HIST_DEPTH];
   logic [COUNT_W-1:0]    sig_rd_ff, oth_rd_ff;

   stage_type             st_ff, st_in;
   logic                  clr_busy_ff, clr_busy_in;
   logic [ADDR_W-1:0]     clr_addr_ff, clr_addr_in;
   logic                  byp_sig_ff, byp_oth_ff;
   logic [COUNT_W-1:0]    byp_data_ff;

   logic [ACC_SUM_W-1:0]  bin_sum;
   logic [ACC_SUM_W-1:0]  bin_full;
   logic [ADDR_W-1:0]     bin_addr;
   logic [ADDR_W-1:0]     rd_addr;

   logic [COUNT_W-1:0]    cur_sig, cur_oth, cur_sel, cnt_next;
   logic                  wr_sig, wr_oth;
   logic [ADDR_W-1:0]     wr_addr;
   logic [COUNT_W-1:0]    wr_data;

   // Round the closed run sum half up to a bin, saturate into the top bin.
   assign bin_sum  = {1'b0, op.acc} + ACC_SUM_W'(ROUND_HALF);
   assign bin_full = bin_sum >> FRAC_BITS;
   assign bin_addr = (bin_full >= ACC_SUM_W'(HIST_DEPTH)) ? ADDR_W'(HIST_DEPTH - 1)
                                                         : ADDR_W'(bin_full);

   always_comb begin
      st_in.rd   = op.rd;
      st_in.bump = op.bump && (bin_full != '0);
      st_in.sel  = op.sel;
      st_in.oor  = (32'(op.idx) >= 32'(HIST_DEPTH));
      st_in.addr = op.rd ? ADDR_W'(op.idx) : bin_addr;
   end

   assign rd_addr = st_in.addr;

   // Use the value just written when the previous cycle hit the same entry.
   assign cur_sig  = byp_sig_ff ? byp_data_ff : sig_rd_ff;
   assign cur_oth  = byp_oth_ff ? byp_data_ff : oth_rd_ff;
   assign cur_sel  = st_ff.sel ? cur_sig : cur_oth;
   assign cnt_next = (cur_sel == '1) ? cur_sel : cur_sel + 1'b1;

   assign wr_sig  = clr_busy_ff || (st_ff.bump && st_ff.sel);
   assign wr_oth  = clr_busy_ff || (st_ff.bump && !st_ff.sel);
   assign wr_addr = clr_busy_ff ? clr_addr_ff : st_ff.addr;
   assign wr_data = clr_busy_ff ? '0 : cnt_next;

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == ADDR_W'(HIST_DEPTH - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   assign rsp_push                   = st_ff.rd;
   assign rsp_data.significant_count = st_ff.oor ? '0 : cur_sig;
   assign rsp_data.other_count       = st_ff.oor ? '0 : cur_oth;
   assign stat.busy                  = clr_busy_ff;
   assign stat.rd_pending            = st_ff.rd;

   always_ff @(posedge clock) begin
      st_ff.sel   <= st_in.sel;
      st_ff.oor   <= st_in.oor;
      st_ff.addr  <= st_in.addr;
      byp_data_ff <= wr_data;
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
         st_ff.bump  <= 1'b0;
         st_ff.rd    <= 1'b0;
         byp_sig_ff  <= 1'b0;
         byp_oth_ff  <= 1'b0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
         st_ff.bump  <= st_in.bump;
         st_ff.rd    <= st_in.rd;
         byp_sig_ff  <= wr_sig && (wr_addr == rd_addr);
         byp_oth_ff  <= wr_oth && (wr_addr == rd_addr);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_sig) begin
         sig_mem[wr_addr] <= wr_data;
      end
      sig_rd_ff <= sig_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wr_oth) begin
         oth_mem[wr_addr] <= wr_data;
      end
      oth_rd_ff <= oth_mem[rd_addr];
   end

endmodule

@@ dv/tb_negative_run_sum_histogram.sv @@
`timescale 1ns / 1ps
// Testbench for negative_run_sum_histogram: a directed table, then random sequences.
// Responses are checked against an in-bench run-sum histogram predictor; needs nrsh_pkg and the RTL.

module tb_negative_run_sum_histogram;
   import nrsh_pkg::*;

   localparam int CLK_HALF_NS   = 4;
   localparam int RESET_CYCLES  = 7;
   // A closing sample reaches the memories through the front-end and histogram registers.
   localparam int SETTLE_CYCLES = 8;
   // Clearing pass plus about 2000 beats at worst-case idling, taken many times over.
   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_ITEMS  = 1900;
   localparam int NUM_PHASES    = 9;
   localparam int MAX_REPORTS   = 10;

   typedef enum logic {ROW_BEAT, ROW_CSR} row_kind_type;

   // One line of the directed table: a beat sent some number of times, or a mask write.
   typedef struct {
      row_kind_type      kind;
      req_type           beat;
      int unsigned       copies;
      bit                typed;      // want holds a hand-written answer
      rsp_type           want;
      logic [MASK_W-1:0] mask_value;
   } stim_row_type;

   // Block ports; the inputs are known from time zero.
   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_ready;
   req_type           req_data    = '0;
   logic              rsp_valid;
   logic              rsp_ready   = 1'b0;
   rsp_type           rsp_data;
   logic              csr_wr_en   = 1'b0;
   logic [MASK_W-1:0] csr_wr_data = '0;

   // Predictor state: open run, position in the sequence, mask and both histograms.
   logic [ACC_W-1:0]   run_sum;
   logic [POS_W-1:0]   seq_pos;
   logic [MASK_W-1:0]  mask_now;
   logic [COUNT_W-1:0] sig_counts   [HIST_DEPTH];
   logic [COUNT_W-1:0] other_counts [HIST_DEPTH];

   rsp_type      pending_counts[$];   // bin counts owed by accepted read beats, oldest first
   stim_row_type stim_rows[$];
   rsp_type      oldest_counts;
   int unsigned  send_idle_pct = 6;
   int unsigned  recv_idle_pct = 80;
   int unsigned  beats_sent    = 0;
   int unsigned  miss_count    = 0;
   int unsigned  cycle_count   = 0;

   negative_run_sum_histogram u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #CLK_HALF_NS clock = ~clock;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // ---------------------------------------------------------------- predictor

   // Round the closed run half up to a bin, clamp to the top bin, count a nonzero bin, clear the run.
   function automatic void count_closed_run(input bit to_sig);
      logic [ACC_SUM_W-1:0] bin;
      bin = ({1'b0, run_sum} + ACC_SUM_W'(ROUND_HALF)) >> FRAC_BITS;
      run_sum = '0;
      if (bin == 0) return;
      if (bin >= HIST_DEPTH) bin = ACC_SUM_W'(HIST_DEPTH - 1);
      if (to_sig) begin
         if (sig_counts[bin[ADDR_W-1:0]] != '1) sig_counts[bin[ADDR_W-1:0]]++;
      end else begin
         if (other_counts[bin[ADDR_W-1:0]] != '1) other_counts[bin[ADDR_W-1:0]]++;
      end
   endfunction

   // Advance the predictor by one accepted beat; return 1 when the beat owes a response.
   function automatic bit predict_histogram_step(input req_type beat, output rsp_type counts);
      logic [MAG_W-1:0]     mag;
      logic [ACC_SUM_W-1:0] sum;
      counts = '0;
      if (beat.command == CMD_READ) begin
         if (beat.bin_index < HIST_DEPTH) begin
            counts.significant_count = sig_counts[beat.bin_index];
            counts.other_count       = other_counts[beat.bin_index];
         end
         return 1'b1;
      end
      if (seq_pos >= POS_W'(mask_now)) begin
         if (beat.sample_value[SAMPLE_W-1]) begin
            mag = (MAG_W'(1) << SAMPLE_W) - {1'b0, beat.sample_value};
            sum = {1'b0, run_sum} + ACC_SUM_W'(mag);
            run_sum = sum[ACC_W] ? '1 : sum[ACC_W-1:0];
            if (beat.last_in_sequence) count_closed_run(beat.is_significant);
         end else begin
            count_closed_run(beat.is_significant);
         end
      end
      if (seq_pos != '1) seq_pos++;
      if (beat.last_in_sequence) begin
         run_sum = '0;
         seq_pos = '0;
      end
      return 1'b0;
   endfunction

   // ---------------------------------------------------------------- drivers

   // Idle at random, then hold valid and payload until the beat is taken; predict on accept.
   task automatic send_beat(input req_type beat, input bit typed, input rsp_type want);
      rsp_type counts;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (!req_ready);
      if (predict_histogram_step(beat, counts))
         pending_counts.insert(pending_counts.size(), typed ? want : counts);
      beats_sent++;
   endtask

   // Drop valid, wait for every owed response, then let in-flight updates land.
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_counts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_mask(input logic [MASK_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      mask_now     = value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   function automatic req_type sample_beat(input logic [SAMPLE_W-1:0] value, input bit last,
                                           input bit sig);
      req_type beat;
      beat                  = '0;
      beat.command          = CMD_SAMPLE;
      beat.sample_value     = value;
      beat.last_in_sequence = last;
      beat.is_significant   = sig;
      beat.bin_index        = BIN_IDX_W'($urandom);   // don't-care on a sample beat
      return beat;
   endfunction

   function automatic req_type read_beat(input logic [BIN_IDX_W-1:0] bin);
      req_type beat;
      beat                  = '0;
      beat.command          = CMD_READ;
      beat.sample_value     = SAMPLE_W'($urandom);     // don't-care on a read beat
      beat.last_in_sequence = 1'($urandom);
      beat.is_significant   = 1'($urandom);
      beat.bin_index        = bin;
      return beat;
   endfunction

   // ---------------------------------------------------------------- directed table

   function automatic void add_sample(input logic [SAMPLE_W-1:0] value, input bit last,
                                      input bit sig, input int unsigned copies);
      stim_row_type row;
      row        = '{kind: ROW_BEAT, beat: '0, copies: copies, typed: 1'b0, want: '0,
                     mask_value: '0};
      row.beat   = sample_beat(value, last, sig);
      stim_rows.insert(stim_rows.size(), row);
   endfunction

   function automatic void add_read(input logic [BIN_IDX_W-1:0] bin, input bit typed,
                                    input logic [COUNT_W-1:0] sig_n,
                                    input logic [COUNT_W-1:0] other_n);
      stim_row_type row;
      row        = '{kind: ROW_BEAT, beat: '0, copies: 1, typed: typed, want: '0,
                     mask_value: '0};
      row.beat   = read_beat(bin);
      row.want   = '{significant_count: sig_n, other_count: other_n};
      stim_rows.insert(stim_rows.size(), row);
   endfunction

   function automatic void add_mask(input logic [MASK_W-1:0] value);
      stim_row_type row;
      row = '{kind: ROW_CSR, beat: '0, copies: 0, typed: 1'b0, want: '0, mask_value: value};
      stim_rows.insert(stim_rows.size(), row);
   endfunction

   function automatic void build_directed_table();
      // Histograms come out of reset cleared, bottom and top bin alike.
      add_read(9'd0, 1'b1, 32'd0, 32'd0);
      add_read(9'd511, 1'b1, 32'd0, 32'd0);
      // Reset mask of 33: the first 33 samples are skipped, the 34th (-1.0, last) counts bin 1.
      add_sample(16'h8000, 1'b0, 1'b1, 33);
      add_sample(16'hFF00, 1'b1, 1'b1, 1);
      add_read(9'd1, 1'b1, 32'd1, 32'd0);
      add_mask(8'd0);
      // Four full-scale negatives give bin 512: saturate into the top bin, closed by +max.
      add_sample(16'h8000, 1'b0, 1'b0, 4);
      add_sample(16'h7FFF, 1'b0, 1'b0, 1);
      add_read(9'd511, 1'b1, 32'd0, 32'd1);
      // Half rounds up: -0.5 then zero closes into bin 1.
      add_sample(16'hFF80, 1'b0, 1'b1, 1);
      add_sample(16'h0000, 1'b0, 1'b1, 1);
      // Just under half rounds to bin 0 and counts nothing; an empty run neither.
      add_sample(16'hFF81, 1'b0, 1'b1, 1);
      add_sample(16'h0001, 1'b0, 1'b1, 1);
      add_sample(16'h0000, 1'b0, 1'b0, 1);
      // A negative last sample is added before its run closes.
      add_sample(16'hFFFF, 1'b1, 1'b1, 1);
      add_sample(16'h8000, 1'b1, 1'b1, 1);
      add_read(9'd1, 1'b0, '0, '0);
      add_read(9'd128, 1'b0, '0, '0);
      add_mask(8'd255);
      // Fully masked sequences: the last bit still restarts the position.
      add_sample(16'hFF00, 1'b1, 1'b0, 2);
      add_mask(8'd1);
      add_sample(16'hFE00, 1'b0, 1'b0, 1);
      add_sample(16'hFE00, 1'b1, 1'b0, 1);
      add_read(9'd2, 1'b0, '0, '0);
   endfunction

   // ---------------------------------------------------------------- random stimulus

   // Small negatives most often, so that low bins fill; also full-range and non-negative values.
   function automatic logic [SAMPLE_W-1:0] pick_sample();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 45) return SAMPLE_W'(0) - SAMPLE_W'($urandom_range(1, 640));
      if (pick < 55) return {1'b1, 15'($urandom)};
      if (pick < 60) return '0;
      if (pick < 85) return {1'b0, 15'($urandom)};
      return SAMPLE_W'($urandom);
   endfunction

   function automatic logic [BIN_IDX_W-1:0] pick_bin();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick < 5) return BIN_IDX_W'($urandom_range(0, 40));
      if (pick < 9) return BIN_IDX_W'($urandom);
      return BIN_IDX_W'(HIST_DEPTH - 1);
   endfunction

   // One sequence: usually long enough to get past the mask, sometimes cut short or broken.
   task automatic send_sequence();
      int unsigned len;
      bit          sig;
      bit          last;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, int'(mask_now) + 1)
                                         : int'(mask_now) + $urandom_range(1, 16);
      sig = 1'($urandom);
      for (int unsigned i = 0; i < len; i++) begin
         if ($urandom_range(0, 4) == 0) send_beat(read_beat(pick_bin()), 1'b0, '0);
         last = (i == len - 1) || ($urandom_range(0, 99) < 2);
         send_beat(sample_beat(pick_sample(), last, ($urandom_range(0, 9) == 0) ? !sig : sig),
                   1'b0, '0);
         if (last) break;
      end
   endtask

   // ---------------------------------------------------------------- checking

   function automatic void report_miss(input string what, input logic [COUNT_W-1:0] want,
                                       input logic [COUNT_W-1:0] got);
      miss_count++;
      if (miss_count <= MAX_REPORTS)
         $display("mismatch in %s at cycle %0d: expected %0d, got %0d",
                  what, cycle_count, want, got);
   endfunction

   // Stall the response side at random; never take a response during reset.
   always @(posedge clock) rsp_ready <= !reset && ($urandom_range(0, 99) >= recv_idle_pct);

   // Compare every taken response beat, field by field, with the oldest owed counts.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_counts.size() == 0) begin
            report_miss("unexpected response", '0, rsp_data.significant_count);
         end else begin
            oldest_counts = pending_counts.pop_front();
            if (rsp_data.significant_count !== oldest_counts.significant_count)
               report_miss("significant_count", oldest_counts.significant_count,
                           rsp_data.significant_count);
            if (rsp_data.other_count !== oldest_counts.other_count)
               report_miss("other_count", oldest_counts.other_count, rsp_data.other_count);
         end
      end
   end

   // Hard stop if the block hangs.
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("negative_run_sum_histogram regression: fail");
      $finish;
   end

   // ---------------------------------------------------------------- sequence of the run

   initial begin
      logic [MASK_W-1:0] phase_masks [NUM_PHASES];
      int unsigned       phase_end;
      req_type           noise;

      phase_masks = '{8'd0, 8'd3, 8'd33, 8'd1, 8'd255, 8'd0, 8'd7, 8'd2, 8'd0};
      run_sum  = '0;
      seq_pos  = '0;
      mask_now = MASK_RESET;
      foreach (sig_counts[i]) begin
         sig_counts[i]   = '0;
         other_counts[i] = '0;
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table; mask writes wait for the block to go idle.
      build_directed_table();
      foreach (stim_rows[i]) begin
         if (stim_rows[i].kind == ROW_CSR) begin
            settle();
            write_mask(stim_rows[i].mask_value);
         end else begin
            repeat (stim_rows[i].copies) send_beat(stim_rows[i].beat, stim_rows[i].typed,
                                                   stim_rows[i].want);
         end
      end

      // Random phases: sender mostly busy first, then receiver mostly busy, then no idling.
      for (int p = 0; p < NUM_PHASES; p++) begin
         settle();
         write_mask(phase_masks[p]);
         case (p / 3)
            0: begin
               send_idle_pct = 6;
               recv_idle_pct = 80;
            end
            1: begin
               send_idle_pct = 80;
               recv_idle_pct = 6;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         phase_end = beats_sent + RANDOM_ITEMS / NUM_PHASES;
         while (beats_sent < phase_end) begin
            if ($urandom_range(0, 19) == 0) begin
               // Noise beat: every field random.
               noise.command          = cmd_type'($urandom_range(0, 1));
               noise.sample_value     = SAMPLE_W'($urandom);
               noise.last_in_sequence = 1'($urandom);
               noise.is_significant   = 1'($urandom);
               noise.bin_index        = BIN_IDX_W'($urandom);
               send_beat(noise, 1'b0, '0);
            end else begin
               send_sequence();
            end
         end
      end

      settle();
      if (miss_count == 0) begin
         $display("negative_run_sum_histogram regression: pass");
      end else begin
         $display("negative_run_sum_histogram regression: fail");
      end
      $finish;
   end

endmodule
